FILE: hdl/sjis_to_escape_converter_unit_defines.svh
// assertion macros for the shift-jis escape converter
// used by the modules of the converter that carry concurrent checks
`ifndef SJIS_TO_ESCAPE_CONVERTER_UNIT_DEFINES_SVH
`define SJIS_TO_ESCAPE_CONVERTER_UNIT_DEFINES_SVH

// same-cycle implication, checks off during reset
`define SJE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checks off during reset
`define SJE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/sjis_esc_pkg.sv
// shared types, constants and byte classification for the escape converter
// no dependencies
package sjis_esc_pkg;

	localparam int MAX_RUN    = 8;
	localparam int RUN_LEN_W  = $clog2(MAX_RUN + 1);
	localparam int RUN_IDX_W  = $clog2(MAX_RUN);
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 1;

	localparam logic [CFG_IDX_W-1:0] CFG_HEX_MODE      = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_KATAKANA_MODE = 1'b1;

	localparam logic [7:0] CH_BACKSLASH = 8'h5c;
	localparam logic [7:0] CH_X         = 8'h78;
	localparam logic [7:0] CH_ZERO      = 8'h30;
	localparam logic [7:0] CH_A_LOWER   = 8'h61;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       stream_end;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       run_last;
		logic       converted_seen;
	} out_item_t;

	typedef struct packed {
		logic hex_mode;
		logic katakana_mode;
	} cfg_t;

	typedef struct packed {
		logic       held_valid;
		logic [7:0] held_lead;
		logic       any_conv;
	} hold_state_t;

	// chars[0] goes out first
	typedef struct packed {
		logic [MAX_RUN-1:0][7:0] chars;
		logic [RUN_LEN_W-1:0]    len;
		logic                    conv;
	} run_t;

	function automatic logic is_lead(input logic [7:0] b);
		return (b >= 8'h81 && b <= 8'h9f) || (b >= 8'he0 && b <= 8'hfc);
	endfunction

	function automatic logic is_trail(input logic [7:0] b);
		return (b >= 8'h40 && b <= 8'h7e) || (b >= 8'h80 && b <= 8'hfc);
	endfunction

	function automatic logic is_katakana(input logic [7:0] b);
		return b >= 8'ha1 && b <= 8'hdf;
	endfunction

	function automatic logic [7:0] hex_digit(input logic [3:0] d);
		return (d < 4'd10) ? CH_ZERO + {4'd0, d} : CH_A_LOWER + {4'd0, d} - 8'd10;
	endfunction

	// four characters of one escape, element 0 first
	function automatic logic [3:0][7:0] escape_chars(input logic [7:0] b, input logic hex);
		logic [3:0][7:0] esc;
		esc[0] = CH_BACKSLASH;
		if (hex) begin
			esc[1] = CH_X;
			esc[2] = hex_digit(b[7:4]);
			esc[3] = hex_digit(b[3:0]);
		end else begin
			esc[1] = CH_ZERO + {6'd0, b[7:6]};
			esc[2] = CH_ZERO + {5'd0, b[5:3]};
			esc[3] = CH_ZERO + {5'd0, b[2:0]};
		end
		return esc;
	endfunction

endpackage

FILE: hdl/sjis_esc_run_build.sv
// builds the character run and next hold state for one registered input byte
// depends on sjis_esc_pkg
module sjis_esc_run_build (
	input  sjis_esc_pkg::in_item_t    item,
	input  sjis_esc_pkg::hold_state_t state_q,
	input  sjis_esc_pkg::cfg_t        cfg,
	output sjis_esc_pkg::run_t        run,
	output sjis_esc_pkg::hold_state_t state_next
);
	import sjis_esc_pkg::*;

	logic                 pair_hit;
	logic                 fresh_hold;
	logic                 fresh_esc;
	logic [3:0][7:0]      fresh_chars;
	logic [RUN_LEN_W-1:0] fresh_len;

	always_comb begin
		pair_hit   = state_q.held_valid && is_trail(item.in_byte);
		fresh_hold = is_lead(item.in_byte) && !item.stream_end;
		fresh_esc  = !fresh_hold && cfg.katakana_mode && is_katakana(item.in_byte);

		fresh_chars = '0;
		fresh_len   = '0;
		if (fresh_esc) begin
			fresh_chars = escape_chars(item.in_byte, cfg.hex_mode);
			fresh_len   = RUN_LEN_W'(4);
		end else if (!fresh_hold) begin
			fresh_chars[0] = item.in_byte;
			fresh_len      = RUN_LEN_W'(1);
		end

		run.chars = '0;
		if (pair_hit) begin
			run.chars[3:0] = escape_chars(state_q.held_lead, cfg.hex_mode);
			run.chars[7:4] = escape_chars(item.in_byte, cfg.hex_mode);
			run.len        = RUN_LEN_W'(MAX_RUN);
		end else if (state_q.held_valid) begin
			// held byte goes out raw ahead of the fresh byte
			run.chars[0]   = state_q.held_lead;
			run.chars[4:1] = fresh_chars;
			run.len        = fresh_len + RUN_LEN_W'(1);
		end else begin
			run.chars[3:0] = fresh_chars;
			run.len        = fresh_len;
		end

		run.conv = state_q.any_conv || pair_hit || fresh_esc;

		if (item.stream_end) begin
			state_next = '0;
		end else begin
			state_next.held_valid = !pair_hit && fresh_hold;
			state_next.held_lead  = (!pair_hit && fresh_hold) ? item.in_byte : state_q.held_lead;
			state_next.any_conv   = run.conv;
		end
	end

endmodule

FILE: hdl/sjis_esc_out_buf.sv
// result register: holds one character run and sends it one character per transfer
// depends on sjis_esc_pkg and the assertion macro header
`include "sjis_to_escape_converter_unit_defines.svh"

module sjis_esc_out_buf (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    load,
	input  sjis_esc_pkg::run_t      run,
	output logic                    can_load,
	output sjis_esc_pkg::out_item_t out_item,
	output logic                    out_valid,
	input  logic                    out_stall
);
	import sjis_esc_pkg::*;

	logic                 valid_q;
	logic [RUN_IDX_W-1:0] idx_q;
	run_t                 run_q;
	logic                 last_char;
	logic                 xfer;

	assign last_char = ({1'b0, idx_q} == run_q.len - RUN_LEN_W'(1));
	assign xfer      = valid_q && !out_stall;
	assign can_load  = !valid_q || (xfer && last_char);

	assign out_valid               = valid_q;
	assign out_item.out_char       = run_q.chars[idx_q];
	assign out_item.run_last       = last_char;
	assign out_item.converted_seen = run_q.conv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			idx_q   <= '0;
		end else if (xfer && last_char) begin
			valid_q <= 1'b0;
		end else if (xfer) begin
			idx_q <= idx_q + RUN_IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			run_q <= run;
		end
	end

	`SJE_ASSERT_IMP(a_idx_in_run, clk, arst_n, valid_q,
		({1'b0, idx_q} < run_q.len), "character index beyond run length")
	`SJE_ASSERT_NEXT(a_run_continues, clk, arst_n, xfer && !last_char && !load,
		valid_q && idx_q == $past(idx_q) + RUN_IDX_W'(1), "run dropped before its last character")
	`SJE_ASSERT_NEXT(a_load_restarts, clk, arst_n, load,
		valid_q && idx_q == '0, "loaded run does not start at its first character")

endmodule

FILE: hdl/sjis_to_escape_converter_unit.sv
// Shift-JIS to escape-text converter, top level
//
// Input channel: one byte per transfer (in_item, in_valid, in_stall). A lead byte
// 0x81-0x9f or 0xe0-0xfc is held until the next byte; a valid trail byte turns the
// pair into two escapes, \xhh or \ooo as chosen by hex_mode, else the held byte
// goes out raw. With katakana_mode set, 0xa1-0xdf is escaped singly.
// Output channel: one character per transfer (out_item, out_valid, out_stall);
// run_last marks the last character caused by one input byte, converted_seen is
// the sticky per-stream conversion flag, cleared after the stream_end byte.
// Configuration: cfg_we/cfg_index/cfg_data, written while the block is idle.
// An accepted byte is registered in the input register and then loaded into the result
// register, which offers its first character; a busy result register holds it back.
// Throughput: one byte per cycle while each byte yields one character and the output
// does not stall; a byte that yields a run of characters (up to 8) occupies the result
// register until its last character is taken, and a held lead byte yields nothing.
// A stall on the output holds the current character and backs up into in_stall
// once the input register is full. Reset clears the held byte, the flag, the
// configuration and both channels' valid state.
// Depends on sjis_esc_pkg, sjis_esc_run_build, sjis_esc_out_buf.
`include "sjis_to_escape_converter_unit_defines.svh"

module sjis_to_escape_converter_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [sjis_esc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [sjis_esc_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  sjis_esc_pkg::in_item_t               in_item,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	output sjis_esc_pkg::out_item_t              out_item,
	output logic                                 out_valid,
	input  logic                                 out_stall
);
	import sjis_esc_pkg::*;

	cfg_t        cfg_q;
	hold_state_t state_q;
	hold_state_t state_next;
	in_item_t    item_s1;
	logic        valid_s1;
	run_t        run;
	logic        can_load;
	logic        advance;
	logic        in_xfer;

	assign advance  = valid_s1 && can_load;
	assign in_stall = valid_s1 && !can_load;
	assign in_xfer  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_HEX_MODE:      cfg_q.hex_mode      <= cfg_data[0];
				CFG_KATAKANA_MODE: cfg_q.katakana_mode <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			item_s1 <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	sjis_esc_run_build u_run_build (
		.item       (item_s1),
		.state_q    (state_q),
		.cfg        (cfg_q),
		.run        (run),
		.state_next (state_next)
	);

	// a byte that only gets held loads nothing
	sjis_esc_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance && run.len != '0),
		.run       (run),
		.can_load  (can_load),
		.out_item  (out_item),
		.out_valid (out_valid),
		.out_stall (out_stall)
	);

	`SJE_ASSERT_NEXT(a_s1_holds, clk, arst_n, valid_s1 && !advance,
		valid_s1 && $stable(item_s1), "input register changed while blocked")
	`SJE_ASSERT_NEXT(a_stream_end_clears, clk, arst_n, advance && item_s1.stream_end,
		!state_q.held_valid && !state_q.any_conv, "state not cleared after stream end")
	`SJE_ASSERT_IMP(a_held_is_lead, clk, arst_n, state_q.held_valid,
		is_lead(state_q.held_lead), "held byte is not a lead byte")

endmodule
